// File: design/multi_timer_event_table_assert.svh
// Assertion macros used by the timer table design.
`ifndef MULTI_TIMER_EVENT_TABLE_ASSERT_SVH
`define MULTI_TIMER_EVENT_TABLE_ASSERT_SVH
// Checks that a condition implies a consequence in the same cycle.
`define MTE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("timer table check failed");
// Checks that a condition implies a consequence in the following cycle.
`define MTE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("timer table check failed");
`endif

// File: design/mte_pkg.sv
// Types and constants of the multi-channel timer table.
package mte_pkg;

    localparam logic [31:0] INVALID_ID  = 32'hFFFF_FFFF;
    localparam int          MAX_RESULTS = 16;

    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_STOP  = 2'd1,
        ACT_TICK  = 2'd2,
        ACT_POLL  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        KIND_START_ACK = 3'd0,
        KIND_STOP_ACK  = 3'd1,
        KIND_TICK_ACK  = 3'd2,
        KIND_EVENT     = 3'd3,
        KIND_NO_EVENTS = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_ID  = 2'd1,
        ST_FULL    = 2'd2,
        ST_DROPPED = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FREE,
        S_STOP_SCAN,
        S_PURGE,
        S_TICK_SCAN,
        S_TICK_EMIT,
        S_POLL_RD,
        S_POLL_OUT,
        S_RESP
    } t_state;

    typedef struct packed {
        t_action     action;
        logic [31:0] now_ms;
        logic [30:0] interval_ms;
        logic        repeat_req;
        logic [31:0] timer_id;
    } t_in_item;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] result_id;
        logic [30:0] elapsed_ms;
        t_status     status;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [31:0] id;
        logic [31:0] start;
        logic [30:0] interval;
        logic        rpt;
    } t_slot;

    typedef struct packed {
        logic [31:0] id;
        logic [30:0] elapsed;
    } t_event;

endpackage

// File: design/mte_ram.sv
// Generic single-write, single-read memory with a registered read port.
module mte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/multi_timer_event_table.sv
// Start scans the valid bits for a free slot; a stop with the invalid ID goes straight to its response.
// Stop scans the slot memory, then purges events of the stopped ID from the event queue.
// Tick repeats slot memory read scans, each emitting the fired timer with the lowest ID, until one finds none.
// Poll returns queued events through the event memory port, or a no-events item when the queue is empty.
// One item is worked on at a time; the output register holds one transfer.
// Synchronous active-low reset clears control state, valid bits and queue count, not memories.
`include "multi_timer_event_table_assert.svh"
module multi_timer_event_table #(
    parameter int NUM_TIMERS  = 16,
    parameter int EVENT_DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  mte_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output mte_pkg::t_out_item o_out
);
    import mte_pkg::*;

    localparam int TW  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int TCW = $clog2(NUM_TIMERS + 1);
    localparam int EW  = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1;
    localparam int ECW = $clog2(EVENT_DEPTH + 1);
    localparam int PW  = $clog2(MAX_RESULTS);

    function automatic logic [EW-1:0] ev_addr(input logic [EW-1:0] base,
                                              input logic [ECW-1:0] off);
        logic [ECW:0] s;
        s = (ECW+1)'(base) + (ECW+1)'(off);
        if (s >= (ECW+1)'(EVENT_DEPTH)) begin
            s = s - (ECW+1)'(EVENT_DEPTH);
        end
        return s[EW-1:0];
    endfunction

    t_state                r_state, n_state;
    t_in_item              r_cmd, n_cmd;
    logic [NUM_TIMERS-1:0] r_valid, n_valid;
    logic [NUM_TIMERS-1:0] r_done, n_done;
    logic [31:0]           r_next_id, n_next_id;
    logic [TCW-1:0]        r_idx, n_idx;
    logic                  r_rd_vld, n_rd_vld;
    logic [TW-1:0]         r_rd_idx, n_rd_idx;
    logic                  r_found, n_found;
    t_slot                 r_best, n_best;
    logic [TW-1:0]         r_best_idx, n_best_idx;
    logic                  r_drop, n_drop;
    logic [EW-1:0]         r_head, n_head;
    logic [ECW-1:0]        r_count, n_count;
    logic [ECW-1:0]        r_rcnt, n_rcnt;
    logic [ECW-1:0]        r_wcnt, n_wcnt;
    logic [PW-1:0]         r_npoll, n_npoll;
    t_out_item             r_resp, n_resp;
    t_out_item             r_out, n_out;
    logic                  r_ovalid, n_ovalid;

    logic          s_we, s_re;
    logic [TW-1:0] s_waddr, s_raddr;
    t_slot         s_wdata, s_rdata;
    logic          e_we, e_re;
    logic [EW-1:0] e_waddr, e_raddr;
    t_event        e_wdata, e_rdata;

    logic          accept, can_load, scan_end, scan_done, purge_done, poll_last;
    logic          free_end, free_hit, fire;
    logic          start_ok;
    logic [TW-1:0] idx_lo;
    logic [31:0]   diff, id_inc, new_id;
    logic [31:0]   best_diff;
    logic [30:0]   best_el;

    mte_ram #(.WIDTH($bits(t_slot)), .DEPTH(NUM_TIMERS)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_re    (s_re),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    mte_ram #(.WIDTH($bits(t_event)), .DEPTH(EVENT_DEPTH)) u_event_ram (
        .i_clk   (i_clk),
        .i_we    (e_we),
        .i_waddr (e_waddr),
        .i_wdata (e_wdata),
        .i_re    (e_re),
        .i_raddr (e_raddr),
        .o_rdata (e_rdata)
    );

    assign accept     = i_in_valid && !o_in_stall;
    assign can_load   = !r_ovalid || !i_out_stall;
    assign idx_lo     = r_idx[TW-1:0];
    assign scan_end   = (r_idx == TCW'(NUM_TIMERS));
    assign scan_done  = scan_end && !r_rd_vld;
    assign free_end   = scan_end;
    assign free_hit   = !scan_end && !r_valid[idx_lo];
    assign purge_done = (r_rcnt == r_count) && !r_rd_vld;
    assign poll_last  = (r_count == ECW'(1)) || (r_npoll == PW'(MAX_RESULTS - 1));
    assign diff       = r_cmd.now_ms - s_rdata.start;
    assign fire       = r_valid[r_rd_idx] && !r_done[r_rd_idx]
                        && (diff >= {1'b0, s_rdata.interval});
    assign best_diff  = r_cmd.now_ms - r_best.start;
    assign best_el    = best_diff[31] ? 31'h7FFF_FFFF : best_diff[30:0];
    assign id_inc     = r_next_id + 32'd1;
    assign new_id     = (id_inc == INVALID_ID) ? 32'd1 : id_inc;
    assign start_ok   = o_out_valid && (o_out.kind == KIND_START_ACK) && (o_out.status == ST_OK);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_in.action)
                        ACT_START: n_state = S_FREE;
                        ACT_STOP:  n_state = (i_in.timer_id == INVALID_ID) ? S_RESP : S_STOP_SCAN;
                        ACT_TICK:  n_state = S_TICK_SCAN;
                        ACT_POLL:  n_state = (r_count == '0) ? S_RESP : S_POLL_RD;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_FREE: begin
                if (free_end || free_hit) begin
                    n_state = S_RESP;
                end
            end
            S_STOP_SCAN: begin
                if (scan_done) begin
                    n_state = S_PURGE;
                end
            end
            S_PURGE: begin
                if (purge_done) begin
                    n_state = S_RESP;
                end
            end
            S_TICK_SCAN: begin
                if (scan_done) begin
                    n_state = r_found ? S_TICK_EMIT : S_RESP;
                end
            end
            S_TICK_EMIT: n_state = S_TICK_SCAN;
            S_POLL_RD:   n_state = S_POLL_OUT;
            S_POLL_OUT: begin
                if (can_load) begin
                    n_state = poll_last ? S_IDLE : S_POLL_RD;
                end
            end
            S_RESP: begin
                if (can_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_cmd      = r_cmd;
        n_valid    = r_valid;
        n_done     = r_done;
        n_next_id  = r_next_id;
        n_idx      = r_idx;
        n_rd_vld   = 1'b0;
        n_rd_idx   = r_rd_idx;
        n_found    = r_found;
        n_best     = r_best;
        n_best_idx = r_best_idx;
        n_drop     = r_drop;
        n_head     = r_head;
        n_count    = r_count;
        n_rcnt     = r_rcnt;
        n_wcnt     = r_wcnt;
        n_npoll    = r_npoll;
        n_resp     = r_resp;
        n_out      = r_out;
        n_ovalid   = r_ovalid && i_out_stall;
        s_we       = 1'b0;
        s_waddr    = r_best_idx;
        s_wdata    = r_best;
        s_re       = 1'b0;
        s_raddr    = idx_lo;
        e_we       = 1'b0;
        e_waddr    = ev_addr(r_head, r_wcnt);
        e_wdata    = e_rdata;
        e_re       = 1'b0;
        e_raddr    = ev_addr(r_head, r_rcnt);
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmd   = i_in;
                    n_idx   = '0;
                    n_done  = '0;
                    n_found = 1'b0;
                    n_drop  = 1'b0;
                    n_rcnt  = '0;
                    n_wcnt  = '0;
                    n_npoll = '0;
                    n_resp  = '{kind: KIND_STOP_ACK, result_id: i_in.timer_id,
                                elapsed_ms: '0, status: ST_BAD_ID, last: 1'b1};
                    if (i_in.action == ACT_POLL) begin
                        n_resp = '{kind: KIND_NO_EVENTS, result_id: '0,
                                   elapsed_ms: '0, status: ST_OK, last: 1'b1};
                    end
                end
            end
            S_FREE: begin
                if (free_end) begin
                    n_resp = '{kind: KIND_START_ACK, result_id: INVALID_ID,
                               elapsed_ms: '0, status: ST_FULL, last: 1'b1};
                end else if (free_hit) begin
                    s_we            = 1'b1;
                    s_waddr         = idx_lo;
                    s_wdata         = '{id: new_id, start: r_cmd.now_ms,
                                        interval: r_cmd.interval_ms, rpt: r_cmd.repeat_req};
                    n_valid[idx_lo] = 1'b1;
                    n_next_id       = new_id;
                    n_resp          = '{kind: KIND_START_ACK, result_id: new_id,
                                        elapsed_ms: '0, status: ST_OK, last: 1'b1};
                end else begin
                    n_idx = r_idx + TCW'(1);
                end
            end
            S_STOP_SCAN: begin
                if (!scan_end) begin
                    s_re     = 1'b1;
                    n_idx    = r_idx + TCW'(1);
                    n_rd_vld = 1'b1;
                    n_rd_idx = idx_lo;
                end
                if (r_rd_vld && (s_rdata.id == r_cmd.timer_id)) begin
                    n_valid[r_rd_idx] = 1'b0;
                end
            end
            S_PURGE: begin
                if (r_rcnt != r_count) begin
                    e_re     = 1'b1;
                    n_rcnt   = r_rcnt + ECW'(1);
                    n_rd_vld = 1'b1;
                end
                if (r_rd_vld && (e_rdata.id != r_cmd.timer_id)) begin
                    e_we   = 1'b1;
                    n_wcnt = r_wcnt + ECW'(1);
                end
                if (purge_done) begin
                    n_count = r_wcnt;
                    n_resp  = '{kind: KIND_STOP_ACK, result_id: r_cmd.timer_id,
                                elapsed_ms: '0, status: ST_OK, last: 1'b1};
                end
            end
            S_TICK_SCAN: begin
                if (!scan_end) begin
                    s_re     = 1'b1;
                    n_idx    = r_idx + TCW'(1);
                    n_rd_vld = 1'b1;
                    n_rd_idx = idx_lo;
                end
                if (r_rd_vld && fire && (!r_found || (s_rdata.id < r_best.id))) begin
                    n_found    = 1'b1;
                    n_best     = s_rdata;
                    n_best_idx = r_rd_idx;
                end
                if (scan_done) begin
                    n_resp = '{kind: KIND_TICK_ACK, result_id: '0, elapsed_ms: '0,
                               status: r_drop ? ST_DROPPED : ST_OK, last: 1'b1};
                end
            end
            S_TICK_EMIT: begin
                s_we          = 1'b1;
                s_wdata       = r_best;
                s_wdata.start = r_cmd.now_ms;
                n_done[r_best_idx] = 1'b1;
                if (!r_best.rpt) begin
                    n_valid[r_best_idx] = 1'b0;
                end
                if (r_count != ECW'(EVENT_DEPTH)) begin
                    e_we    = 1'b1;
                    e_waddr = ev_addr(r_head, r_count);
                    e_wdata = '{id: r_best.id, elapsed: best_el};
                    n_count = r_count + ECW'(1);
                end else begin
                    n_drop = 1'b1;
                end
                n_found = 1'b0;
                n_idx   = '0;
            end
            S_POLL_RD: begin
                e_re    = 1'b1;
                e_raddr = r_head;
            end
            S_POLL_OUT: begin
                if (can_load) begin
                    n_out    = '{kind: KIND_EVENT, result_id: e_rdata.id,
                                 elapsed_ms: e_rdata.elapsed, status: ST_OK, last: poll_last};
                    n_ovalid = 1'b1;
                    n_head   = ev_addr(r_head, ECW'(1));
                    n_count  = r_count - ECW'(1);
                    n_npoll  = r_npoll + PW'(1);
                end
            end
            S_RESP: begin
                if (can_load) begin
                    n_out    = r_resp;
                    n_ovalid = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_done    <= '0;
            r_next_id <= '0;
            r_idx     <= '0;
            r_rd_vld  <= 1'b0;
            r_found   <= 1'b0;
            r_drop    <= 1'b0;
            r_head    <= '0;
            r_count   <= '0;
            r_rcnt    <= '0;
            r_wcnt    <= '0;
            r_npoll   <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_valid   <= n_valid;
            r_done    <= n_done;
            r_next_id <= n_next_id;
            r_idx     <= n_idx;
            r_rd_vld  <= n_rd_vld;
            r_found   <= n_found;
            r_drop    <= n_drop;
            r_head    <= n_head;
            r_count   <= n_count;
            r_rcnt    <= n_rcnt;
            r_wcnt    <= n_wcnt;
            r_npoll   <= n_npoll;
            r_ovalid  <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_rd_idx   <= n_rd_idx;
        r_best     <= n_best;
        r_best_idx <= n_best_idx;
        r_resp     <= n_resp;
        r_out      <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;

    `MTE_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= ECW'(EVENT_DEPTH))
    `MTE_ASSERT_NOW(a_id_counter_valid, i_clk, i_rst_n, 1'b1, r_next_id != INVALID_ID)
    `MTE_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, accept, r_state != S_IDLE)
    `MTE_ASSERT_NOW(a_start_id_valid, i_clk, i_rst_n, start_ok, o_out.result_id != INVALID_ID)

endmodule
